// ===== src/sweep_times_to_direction_vector_top_macros.svh =====
// Assertion macros for the sweep direction block.
`ifndef SWEEP_TIMES_TO_DIRECTION_VECTOR_TOP_MACROS_SVH
`define SWEEP_TIMES_TO_DIRECTION_VECTOR_TOP_MACROS_SVH

// Condition now implies consequence in the next cycle.
`define SWDV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sweep direction check failed");

// Condition now implies consequence in the same cycle.
`define SWDV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sweep direction check failed");

`endif

// ===== src/swdv_pkg.sv =====
`timescale 1ns / 1ps
package swdv_pkg;
  localparam int TIME_BITS         = 32;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int FRAC_BITS         = 16;
  localparam int Q_W               = FRAC_BITS + 1;
  localparam int CW                = 34;
  localparam int IDX_W             = 5;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // One divider lane: remainder and quotient so far
  typedef struct packed {
    logic [TIME_BITS-1:0] rem;
    logic [Q_W-1:0]       quo;
  } div_lane_t;

  typedef struct packed {
    logic                 v;
    logic                 clamped;
    logic [TIME_BITS-1:0] period;
    div_lane_t            a;
    div_lane_t            b;
  } div_t;

  // One rotation lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cord_lane_t;

  typedef struct packed {
    logic       v;
    logic       clamped;
    cord_lane_t a;
    cord_lane_t b;
  } cord_t;

  // Truncated Q30 arctangent of 2^-i
  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return $signed({2'b00, r});
  endfunction

  // Saturate a signed value to Q1.15
  function automatic logic [15:0] sat16(input logic signed [CW-1:0] v);
    logic [15:0] r;
    if (v > 34'sd32767) r = 16'h7FFF;
    else if (v < -34'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

// ===== src/sweep_times_to_direction_vector_top.sv =====
`timescale 1ns / 1ps
// Sweep-time to direction vector. Takes one pair of sweep times per beat and
// returns x, y, z of the unit vector in Q1.15 with a clamp flag, at one pair
// per cycle while the output beat is not held. The stages are one input stage,
// a row of 16 restoring-divider cells, angle scaling, range reduction, a row
// of 16 CORDIC cells, product and rounding stages. The whole row advances
// together; it stalls only while the output beat waits.
module sweep_times_to_direction_vector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_sweep_time, second_sweep_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // dir_x, dir_y, dir_z
  output logic        out_tuser   // time_clamped
);
  import swdv_pkg::*;
  `include "sweep_times_to_direction_vector_top_macros.svh"

  logic [31:0] period_r;
  logic        adv;
  logic [TIME_BITS-1:0] p_eff, ta, tb, tac, tbc;
  logic        clamp_a, clamp_b;

  div_t  div_c [0:FRAC_BITS];
  div_t  s0_nxt;
  cord_t cord_c [0:CORDIC_ITERATIONS];

  // Hold the period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 32'd8333;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Clamp times and take the integer quotient bit
  always_comb begin
    p_eff   = (period_r[TIME_BITS-1:0] == '0) ? TIME_BITS'(1) : period_r[TIME_BITS-1:0];
    ta      = in_tdata[TIME_BITS-1:0];
    tb      = in_tdata[32+TIME_BITS-1:32];
    clamp_a = ta > p_eff;
    clamp_b = tb > p_eff;
    tac     = clamp_a ? p_eff : ta;
    tbc     = clamp_b ? p_eff : tb;
    s0_nxt.v       = in_tvalid;
    s0_nxt.clamped = clamp_a || clamp_b;
    s0_nxt.period  = p_eff;
    s0_nxt.a.rem   = (tac == p_eff) ? '0 : tac;
    s0_nxt.a.quo   = Q_W'(tac == p_eff);
    s0_nxt.b.rem   = (tbc == p_eff) ? '0 : tbc;
    s0_nxt.b.quo   = Q_W'(tbc == p_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_c[0].v <= 1'b0;
    end else if (adv) begin
      div_c[0] <= s0_nxt;
    end
  end

  // Divider row
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    swdv_div_cell u_div (
      .clk(clk), .rst_n(rst_n), .en(adv), .d_i(div_c[i]), .d_o(div_c[i+1])
    );
  end

  // Scale ratios to Q30 angles
  logic              ang_v_r, ang_cl_r;
  logic [31:0]       ang_a_r, ang_b_r;
  logic [Q_W-1:0]    qb;
  logic [Q_W+31:0]   ma, mb;
  always_comb begin
    qb = Q_W'(1 << FRAC_BITS) - div_c[FRAC_BITS].b.quo;
    ma = div_c[FRAC_BITS].a.quo * PI_Q30 + (Q_W+32)'(1 << (FRAC_BITS-1));
    mb = qb * PI_Q30 + (Q_W+32)'(1 << (FRAC_BITS-1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r <= 1'b0;
    end else if (adv) begin
      ang_v_r  <= div_c[FRAC_BITS].v;
      ang_cl_r <= div_c[FRAC_BITS].clamped;
      ang_a_r  <= ma[FRAC_BITS+31:FRAC_BITS];
      ang_b_r  <= mb[FRAC_BITS+31:FRAC_BITS];
    end
  end

  // Fold into the first quadrant and seed the rotations
  cord_t c0_nxt;
  always_comb begin
    c0_nxt.v       = ang_v_r;
    c0_nxt.clamped = ang_cl_r;
    c0_nxt.a.x     = CORDIC_GAIN_Q30;
    c0_nxt.a.y     = '0;
    c0_nxt.a.neg   = ang_a_r > HALF_PI_Q30;
    c0_nxt.a.z     = $signed({2'b00, c0_nxt.a.neg ? PI_Q30 - ang_a_r : ang_a_r});
    c0_nxt.b.x     = CORDIC_GAIN_Q30;
    c0_nxt.b.y     = '0;
    c0_nxt.b.neg   = ang_b_r > HALF_PI_Q30;
    c0_nxt.b.z     = $signed({2'b00, c0_nxt.b.neg ? PI_Q30 - ang_b_r : ang_b_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cord_c[0].v <= 1'b0;
    end else if (adv) begin
      cord_c[0] <= c0_nxt;
    end
  end

  // CORDIC row
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cord
    swdv_cordic_cell u_cord (
      .clk(clk), .rst_n(rst_n), .en(adv), .idx(IDX_W'(i)),
      .c_i(cord_c[i]), .c_o(cord_c[i+1])
    );
  end

  // Form products
  cord_t cl;
  logic signed [31:0] sg, st, ct;
  logic signed [CW-1:0] cg;
  logic signed [63:0] px_r, py_r;
  logic signed [CW-1:0] cz_r;
  logic pr_v_r, pr_cl_r;
  always_comb begin
    cl = cord_c[CORDIC_ITERATIONS];
    sg = cl.a.y[31:0];
    st = cl.b.y[31:0];
    ct = cl.b.neg ? -cl.b.x[31:0] : cl.b.x[31:0];
    cg = cl.a.neg ? -cl.a.x : cl.a.x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (adv) begin
      pr_v_r  <= cl.v;
      pr_cl_r <= cl.clamped;
      px_r    <= sg * ct;
      py_r    <= sg * st;
      cz_r    <= cg;
    end
  end

  // Round to Q1.15 and saturate into the output beat
  logic signed [63:0]   rx, ry;
  logic signed [CW-1:0] rz;
  always_comb begin
    rx = (px_r + (64'sd1 <<< 44)) >>> 45;
    ry = (py_r + (64'sd1 <<< 44)) >>> 45;
    rz = (cz_r + (34'sd1 <<< 14)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= pr_v_r;
      out_tdata  <= {sat16(rz), sat16(ry[CW-1:0]), sat16(rx[CW-1:0])};
      out_tuser  <= pr_cl_r;
    end
  end

  // Checks
  `SWDV_ASSERT_NOW(a_ready_follows_sink, out_tready, in_tready)
  `SWDV_ASSERT_NEXT(a_accept_enters_row, in_tvalid && in_tready, div_c[0].v)
  `SWDV_ASSERT_NEXT(a_stall_holds_row, !in_tready, $stable(cord_c[0]) && $stable(div_c[0]))
endmodule

// ===== src/swdv_div_cell.sv =====
`timescale 1ns / 1ps
module swdv_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  swdv_pkg::div_t d_i,
  output swdv_pkg::div_t d_o
);
  import swdv_pkg::*;

  div_t d_r, d_nxt;
  logic [TIME_BITS:0] ra2, rb2, pe;
  logic ge_a, ge_b;

  // Shift remainder, compare with period, subtract on a hit
  always_comb begin
    pe    = {1'b0, d_i.period};
    ra2   = {d_i.a.rem, 1'b0};
    rb2   = {d_i.b.rem, 1'b0};
    ge_a  = ra2 >= pe;
    ge_b  = rb2 >= pe;
    d_nxt = d_i;
    d_nxt.a.rem = ge_a ? TIME_BITS'(ra2 - pe) : TIME_BITS'(ra2);
    d_nxt.b.rem = ge_b ? TIME_BITS'(rb2 - pe) : TIME_BITS'(rb2);
    d_nxt.a.quo = {d_i.a.quo[Q_W-2:0], ge_a};
    d_nxt.b.quo = {d_i.b.quo[Q_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.v <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule

// ===== src/swdv_cordic_cell.sv =====
`timescale 1ns / 1ps
module swdv_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [swdv_pkg::IDX_W-1:0]   idx,
  input  swdv_pkg::cord_t              c_i,
  output swdv_pkg::cord_t              c_o
);
  import swdv_pkg::*;

  cord_t c_r, c_nxt;
  logic signed [CW-1:0] at;

  function automatic cord_lane_t rot(input cord_lane_t l, input logic [IDX_W-1:0] s,
                                     input logic signed [CW-1:0] ang);
    cord_lane_t o;
    logic signed [CW-1:0] dx, dy;
    dx = l.y >>> s;
    dy = l.x >>> s;
    o  = l;
    if (!l.z[CW-1]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - ang;
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + ang;
    end
    return o;
  endfunction

  // Rotate both lanes by one micro-angle
  always_comb begin
    at    = atan_q30(idx);
    c_nxt = c_i;
    c_nxt.a = rot(c_i.a, idx, at);
    c_nxt.b = rot(c_i.b, idx, at);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.v <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import swdv_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               clamped;
  } dir_vec_t;

  typedef struct {
    logic [31:0]        t1;
    logic [31:0]        t2;
    bit                 pinned;
    logic signed [15:0] z;
    logic               clamped;
  } sweep_row_t;

  // Truncated Q30 arctangent of 2^-i
  localparam longint ATAN_TAB [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  logic [31:0] period_shadow = 32'd8333;
  dir_vec_t    vec_fifo[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          steady = 1'b0;
  bit          row_pinned = 1'b0;
  logic signed [15:0] row_z = '0;
  logic        row_clamped = 1'b0;

  sweep_times_to_direction_vector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // first_sweep_time, second_sweep_time
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // dir_x, dir_y, dir_z
    .out_tuser  (out_tuser)    // time_clamped
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor(t * 2^16 / p), restoring division
  function automatic longint sweep_ratio(input longint t, input longint p);
    longint q;
    longint r;
    q = 0;
    r = t;
    if (r >= p) begin
      q = 1;
      r -= p;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= p) begin
        q |= 1;
        r -= p;
      end
    end
    return q;
  endfunction

  // Q30 sine and cosine of q * pi / 2^16
  function automatic void rotate_angle(input longint q, output longint s, output longint c);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    a = (q * longint'(PI_Q30) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    flip = 1'b0;
    if (a > longint'(HALF_PI_Q30)) begin
      a = longint'(PI_Q30) - a;
      flip = 1'b1;
    end
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = a;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TAB[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TAB[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v, input int shift);
    longint r;
    r = (v + (longint'(1) << (shift - 1))) >>> shift;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic dir_vec_t predict_direction(input logic [31:0] t1_in,
                                                 input logic [31:0] t2_in);
    dir_vec_t v;
    longint   p;
    longint   t1;
    longint   t2;
    longint   sg;
    longint   cg;
    longint   st;
    longint   ct;
    p = longint'(period_shadow);
    t1 = longint'(t1_in);
    t2 = longint'(t2_in);
    v.clamped = 1'b0;
    if (p == 0) p = 1;
    if (t1 > p) begin
      t1 = p;
      v.clamped = 1'b1;
    end
    if (t2 > p) begin
      t2 = p;
      v.clamped = 1'b1;
    end
    rotate_angle(sweep_ratio(t1, p), sg, cg);
    rotate_angle((longint'(1) << FRAC_BITS) - sweep_ratio(t2, p), st, ct);
    v.x = round_q15(sg * ct, 45);
    v.y = round_q15(sg * st, 45);
    v.z = round_q15(cg, 15);
    return v;
  endfunction

  // Predict on every accepted input beat; pinned rows override z and flag
  always @(negedge clk) begin
    dir_vec_t v;
    if (rst_n && in_tvalid && in_tready) begin
      v = predict_direction(in_tdata[31:0], in_tdata[63:32]);
      if (row_pinned) begin
        v.z = row_z;
        v.clamped = row_clamped;
      end
      vec_fifo = {vec_fifo, v};
    end
  end

  // Compare each output beat with the oldest prediction
  always @(negedge clk) begin
    dir_vec_t v;
    if (rst_n && out_tvalid && out_tready) begin
      if (vec_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: %h %b", out_tdata, out_tuser);
      end else begin
        v = vec_fifo.pop_front();
        if (out_tdata[15:0] !== v.x || out_tdata[31:16] !== v.y ||
            out_tdata[47:32] !== v.z || out_tuser !== v.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%0d c=%b got x=%0d y=%0d z=%0d c=%b",
                     v.x, v.y, v.z, v.clamped,
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]),
                     $signed(out_tdata[47:32]), out_tuser);
        end
      end
    end
  end

  // Back-pressure on the result side
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 19);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pair(input logic [31:0] t1, input logic [31:0] t2);
    // Idle for a random number of cycles, each with odds of 19 in 100
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t2, t1};
    @(negedge clk);
    while (!in_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Hold until every prediction has been matched, then let the pipe settle
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (vec_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    period_shadow = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time(input logic [31:0] p);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return (p == 0) ? 32'd0 : 32'($urandom_range(p, 0));
    if (sel < 78) return p;
    if (sel < 84) return 32'd0;
    if (sel < 90) return (p == 32'hFFFFFFFF) ? p : p + 32'd1;
    return $urandom;
  endfunction

  sweep_row_t  rows[$];
  logic [31:0] periods[8];

  initial begin
    // Directed rows; z and flag pinned where obvious
    rows = '{
      '{32'd0,          32'd0,          1'b1, 16'sd32767,  1'b0},
      '{32'd8333,       32'd8333,       1'b1, -16'sd32768, 1'b0},
      '{32'd8334,       32'd0,          1'b1, -16'sd32768, 1'b1},
      '{32'd0,          32'hFFFFFFFF,   1'b1, 16'sd32767,  1'b1},
      '{32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, -16'sd32768, 1'b1},
      '{32'd4166,       32'd4166,       1'b0, '0, 1'b0},
      '{32'd4167,       32'd2083,       1'b0, '0, 1'b0},
      '{32'd2083,       32'd6250,       1'b0, '0, 1'b0},
      '{32'd6250,       32'd0,          1'b0, '0, 1'b0},
      '{32'd1,          32'd1,          1'b0, '0, 1'b0},
      '{32'd8332,       32'd8332,       1'b0, '0, 1'b0},
      '{32'd5555,       32'd8333,       1'b0, '0, 1'b0},
      '{32'd8333,       32'd9000,       1'b1, -16'sd32768, 1'b1},
      '{32'h80000000,   32'd100,        1'b1, -16'sd32768, 1'b1},
      '{32'd3000,       32'h7FFFFFFF,   1'b0, '0, 1'b1}
    };
    periods = '{32'd8333, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd1000,
                $urandom, 32'($urandom_range(65535, 2)), 32'd8333};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row_pinned  = rows[i].pinned;
      row_z       = rows[i].z;
      row_clamped = rows[i].clamped;
      send_pair(rows[i].t1, rows[i].t2);
    end
    row_pinned = 1'b0;
    drain();

    foreach (periods[ph]) begin
      write_period(periods[ph]);
      steady = (ph == 4);
      for (int n = 0; n < 160; n++) begin
        send_pair(pick_time(period_shadow), pick_time(period_shadow));
        // Pause the sender mid-phase until the output side has caught up
        if (n == 80 && ph == 1) drain();
      end
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0 && vec_fifo.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/swdv_pkg.sv
src/swdv_div_cell.sv
src/swdv_cordic_cell.sv
src/sweep_times_to_direction_vector_top.sv
dv/tb_top.sv
